[hdl/crbm_pkg.sv]
// Shared constants, payload types and record types for the region relabel block.
`timescale 1ns / 1ps

package crbm_pkg;

    localparam int MAX_PIXELS  = 524288;
    localparam int MAX_WIDTH   = 1024;
    localparam int ROW_LIMIT   = 1024;

    localparam int ROOT_W      = 19;
    localparam int LABEL_W     = 19;
    localparam int COUNT_W     = 20;
    localparam int POS_W       = 10;
    localparam int CFG_W       = 11;
    localparam int CFG_AW      = 1;

    localparam int PIX_AW      = $clog2(MAX_PIXELS);
    localparam int COL_AW      = $clog2(MAX_WIDTH);

    localparam logic [CFG_AW-1:0] REG_FRAME_WIDTH  = CFG_AW'(0);
    localparam logic [CFG_AW-1:0] REG_FRAME_HEIGHT = CFG_AW'(1);

    localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic REPORT_LABEL    = 1'b0;
    localparam logic REPORT_BOUNDARY = 1'b1;

    localparam int SLOT_LABEL = 0;
    localparam int SLOT_DIAG  = 1;
    localparam int SLOT_UP    = 2;
    localparam int SLOT_LEFT  = 3;
    localparam int SLOT_SELF  = 4;
    localparam int SLOT_N     = 5;

    typedef struct packed {
        logic [ROOT_W-1:0] root_id;
        logic              frame_start;
    } in_item_t;

    typedef struct packed {
        logic               report_kind;
        logic [POS_W-1:0]   pos_x;
        logic [POS_W-1:0]   pos_y;
        logic [LABEL_W-1:0] report_value;
        logic [COUNT_W-1:0] region_total;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic [ROOT_W-1:0] root_id;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic              frame_start;
        logic              wrap;
        logic              has_diag;
        logic              has_up;
        logic              has_left;
        logic              has_self;
        logic [ROOT_W-1:0] left_root;
    } pix_t;

    typedef struct packed {
        logic [POS_W-1:0]   pos_x;
        logic [POS_W-1:0]   pos_y;
        logic [LABEL_W-1:0] label;
        logic [COUNT_W-1:0] total;
        logic               has_diag;
        logic               bnd_diag;
        logic               has_up;
        logic               bnd_up;
        logic               has_left;
        logic               bnd_left;
        logic               has_self;
    } rec_t;

endpackage

[hdl/crbm_ram.sv]
// Generic single-clock RAM with one write port and one registered read port (read-first).
`timescale 1ns / 1ps

module crbm_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 19
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/crbm_scan.sv]
// Frame geometry registers, raster position counters and left-neighbor tracking.
`timescale 1ns / 1ps

module crbm_scan (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [crbm_pkg::CFG_AW-1:0] cfg_addr,
    input  logic [crbm_pkg::CFG_W-1:0] cfg_data,
    input  logic                       accept,
    input  crbm_pkg::in_item_t         item,
    output crbm_pkg::pix_t             pix
);

    logic [crbm_pkg::CFG_W-1:0]  width_reg;
    logic [crbm_pkg::CFG_W-1:0]  height_reg;
    logic [crbm_pkg::CFG_W-1:0]  w_eff;
    logic [crbm_pkg::CFG_W-1:0]  h_eff;
    logic [crbm_pkg::CFG_W-1:0]  last_col;
    logic [crbm_pkg::CFG_W-1:0]  last_row;
    logic [crbm_pkg::POS_W-1:0]  col_reg;
    logic [crbm_pkg::POS_W-1:0]  col_next;
    logic [crbm_pkg::POS_W-1:0]  row_reg;
    logic [crbm_pkg::POS_W-1:0]  row_next;
    logic [crbm_pkg::POS_W-1:0]  x;
    logic [crbm_pkg::POS_W-1:0]  y;
    logic [crbm_pkg::ROOT_W-1:0] left_reg;
    logic                        endrow;
    logic                        lastrow;

    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = crbm_pkg::CFG_W'(1);
        end
        else if (width_reg > crbm_pkg::CFG_W'(crbm_pkg::MAX_WIDTH))
        begin
            w_eff = crbm_pkg::CFG_W'(crbm_pkg::MAX_WIDTH);
        end
        else
        begin
            w_eff = width_reg;
        end

        if (height_reg == '0)
        begin
            h_eff = crbm_pkg::CFG_W'(1);
        end
        else if (height_reg > crbm_pkg::CFG_W'(crbm_pkg::ROW_LIMIT))
        begin
            h_eff = crbm_pkg::CFG_W'(crbm_pkg::ROW_LIMIT);
        end
        else
        begin
            h_eff = height_reg;
        end

        last_col = w_eff - crbm_pkg::CFG_W'(1);
        last_row = h_eff - crbm_pkg::CFG_W'(1);

        x = item.frame_start ? '0 : col_reg;
        y = item.frame_start ? '0 : row_reg;
        endrow  = crbm_pkg::CFG_W'(x) >= last_col;
        lastrow = crbm_pkg::CFG_W'(y) >= last_row;

        col_next = endrow ? '0 : x + crbm_pkg::POS_W'(1);
        if (endrow)
        begin
            row_next = lastrow ? '0 : y + crbm_pkg::POS_W'(1);
        end
        else
        begin
            row_next = y;
        end

        pix.root_id     = item.root_id;
        pix.pos_x       = x;
        pix.pos_y       = y;
        pix.frame_start = item.frame_start;
        pix.wrap        = endrow && lastrow;
        pix.has_diag    = (y != '0) && (x != '0);
        pix.has_up      = (y != '0) && endrow;
        pix.has_left    = lastrow && (x != '0);
        pix.has_self    = lastrow && endrow;
        pix.left_root   = left_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= crbm_pkg::WIDTH_RESET;
            height_reg <= crbm_pkg::HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                crbm_pkg::REG_FRAME_WIDTH:  width_reg  <= cfg_data;
                crbm_pkg::REG_FRAME_HEIGHT: height_reg <= cfg_data;
                default:                    width_reg  <= width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            left_reg <= '0;
        end
        else if (accept)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            left_reg <= item.root_id;
        end
    end

endmodule

[hdl/crbm_label.sv]
// Sparse-set label tables and row memory with a read-modify-write pipeline and forwarding.
`timescale 1ns / 1ps

module crbm_label (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  crbm_pkg::pix_t pix,
    output logic           rec_valid,
    output crbm_pkg::rec_t rec,
    output logic [1:0]     inflight
);

    typedef struct packed {
        logic [crbm_pkg::ROOT_W-1:0]  root_id;
        logic [crbm_pkg::POS_W-1:0]   pos_x;
        logic [crbm_pkg::POS_W-1:0]   pos_y;
        logic                         frame_start;
        logic                         wrap;
        logic [crbm_pkg::LABEL_W-1:0] lab_raw;
        logic                         has_diag;
        logic                         bnd_diag;
        logic                         has_up;
        logic                         bnd_up;
        logic                         has_left;
        logic                         bnd_left;
        logic                         has_self;
    } stage2_t;

    logic                          p1_valid_reg;
    crbm_pkg::pix_t                p1_reg;
    logic                          p2_valid_reg;
    stage2_t                       p2_reg;
    stage2_t                       p2_next;
    logic [crbm_pkg::ROOT_W-1:0]   ul_reg;
    logic [crbm_pkg::COUNT_W-1:0]  count_reg;
    logic [crbm_pkg::COUNT_W-1:0]  count_next;
    logic                          wb_valid_reg;
    logic [crbm_pkg::ROOT_W-1:0]   wb_root_reg;
    logic [crbm_pkg::LABEL_W-1:0]  wb_lab_reg;

    logic [crbm_pkg::LABEL_W-1:0]  r2l_rdata;
    logic [crbm_pkg::ROOT_W-1:0]   l2r_rdata;
    logic [crbm_pkg::ROOT_W-1:0]   above;
    logic [crbm_pkg::LABEL_W-1:0]  s1_lab;

    logic [crbm_pkg::ROOT_W-1:0]   l2r_data;
    logic [crbm_pkg::COUNT_W-1:0]  eff_count;
    logic [crbm_pkg::COUNT_W-1:0]  total;
    logic                          hit;
    logic                          room;
    logic                          wr_en;
    logic [crbm_pkg::LABEL_W-1:0]  wr_lab;

    crbm_ram #(
        .DEPTH (crbm_pkg::MAX_PIXELS),
        .WIDTH (crbm_pkg::LABEL_W)
    ) u_root_to_label (
        .clk   (clk),
        .we    (wr_en),
        .waddr (crbm_pkg::PIX_AW'(p2_reg.root_id)),
        .wdata (wr_lab),
        .raddr (crbm_pkg::PIX_AW'(pix.root_id)),
        .rdata (r2l_rdata)
    );

    crbm_ram #(
        .DEPTH (crbm_pkg::MAX_PIXELS),
        .WIDTH (crbm_pkg::ROOT_W)
    ) u_label_to_root (
        .clk   (clk),
        .we    (wr_en),
        .waddr (crbm_pkg::PIX_AW'(wr_lab)),
        .wdata (p2_reg.root_id),
        .raddr (crbm_pkg::PIX_AW'(s1_lab)),
        .rdata (l2r_rdata)
    );

    crbm_ram #(
        .DEPTH (crbm_pkg::MAX_WIDTH),
        .WIDTH (crbm_pkg::ROOT_W)
    ) u_prior_row (
        .clk   (clk),
        .we    (accept),
        .waddr (crbm_pkg::COL_AW'(pix.pos_x)),
        .wdata (pix.root_id),
        .raddr (crbm_pkg::COL_AW'(pix.pos_x)),
        .rdata (above)
    );

    // The label read of the item in the first stage misses the write landing at the
    // same edge and the write still pending in the second stage; newer write wins.
    always_comb
    begin
        s1_lab = r2l_rdata;
        if (wb_valid_reg && (wb_root_reg == p1_reg.root_id))
        begin
            s1_lab = wb_lab_reg;
        end
        if (wr_en && (p2_reg.root_id == p1_reg.root_id))
        begin
            s1_lab = wr_lab;
        end

        p2_next.root_id     = p1_reg.root_id;
        p2_next.pos_x       = p1_reg.pos_x;
        p2_next.pos_y       = p1_reg.pos_y;
        p2_next.frame_start = p1_reg.frame_start;
        p2_next.wrap        = p1_reg.wrap;
        p2_next.lab_raw     = s1_lab;
        p2_next.has_diag    = p1_reg.has_diag;
        p2_next.bnd_diag    = (ul_reg != above) || (ul_reg != p1_reg.left_root)
                              || (ul_reg != p1_reg.root_id);
        p2_next.has_up      = p1_reg.has_up;
        p2_next.bnd_up      = above != p1_reg.root_id;
        p2_next.has_left    = p1_reg.has_left;
        p2_next.bnd_left    = p1_reg.left_root != p1_reg.root_id;
        p2_next.has_self    = p1_reg.has_self;
    end

    always_comb
    begin
        l2r_data = l2r_rdata;
        if (wb_valid_reg && (wb_lab_reg == p2_reg.lab_raw))
        begin
            l2r_data = wb_root_reg;
        end

        eff_count = p2_reg.frame_start ? '0 : count_reg;
        hit  = (crbm_pkg::COUNT_W'(p2_reg.lab_raw) < eff_count)
               && (l2r_data == p2_reg.root_id);
        room = eff_count < crbm_pkg::COUNT_W'(crbm_pkg::MAX_PIXELS);
        wr_en = p2_valid_reg && !hit && room;

        if (hit)
        begin
            wr_lab = p2_reg.lab_raw;
        end
        else if (room)
        begin
            wr_lab = eff_count[crbm_pkg::LABEL_W-1:0];
        end
        else
        begin
            wr_lab = crbm_pkg::LABEL_W'(crbm_pkg::MAX_PIXELS - 1);
        end

        total = eff_count + (wr_en ? crbm_pkg::COUNT_W'(1) : '0);
        if (p2_valid_reg)
        begin
            count_next = p2_reg.wrap ? '0 : total;
        end
        else
        begin
            count_next = count_reg;
        end

        rec_valid    = p2_valid_reg;
        rec.pos_x    = p2_reg.pos_x;
        rec.pos_y    = p2_reg.pos_y;
        rec.label    = wr_lab;
        rec.total    = total;
        rec.has_diag = p2_reg.has_diag;
        rec.bnd_diag = p2_reg.bnd_diag;
        rec.has_up   = p2_reg.has_up;
        rec.bnd_up   = p2_reg.bnd_up;
        rec.has_left = p2_reg.has_left;
        rec.bnd_left = p2_reg.bnd_left;
        rec.has_self = p2_reg.has_self;

        inflight = {1'b0, p1_valid_reg} + {1'b0, p2_valid_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            wb_valid_reg <= 1'b0;
            ul_reg       <= '0;
            count_reg    <= '0;
        end
        else
        begin
            p1_valid_reg <= accept;
            p2_valid_reg <= p1_valid_reg;
            wb_valid_reg <= wr_en;
            count_reg    <= count_next;
            if (p1_valid_reg)
            begin
                ul_reg <= above;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_reg <= pix;
        end
        if (p1_valid_reg)
        begin
            p2_reg <= p2_next;
        end
        wb_root_reg <= p2_reg.root_id;
        wb_lab_reg  <= wr_lab;
    end

endmodule

[hdl/crbm_report.sv]
// Record queue and report serializer feeding the registered output channel.
`timescale 1ns / 1ps

module crbm_report (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rec_valid,
    input  crbm_pkg::rec_t                rec,
    output logic                          out_valid,
    input  logic                          out_ready,
    output crbm_pkg::out_item_t           out_data,
    output logic [crbm_pkg::QUEUE_CW-1:0] q_count
);

    crbm_pkg::rec_t                  q_mem [crbm_pkg::QUEUE_DEPTH];
    logic [crbm_pkg::QUEUE_AW-1:0]   head_reg;
    logic [crbm_pkg::QUEUE_AW-1:0]   tail_reg;
    logic [crbm_pkg::QUEUE_CW-1:0]   count_reg;
    logic [crbm_pkg::QUEUE_CW-1:0]   count_next;
    logic                            started_reg;
    logic [crbm_pkg::SLOT_N-1:0]     mask_reg;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    crbm_pkg::out_item_t             out_reg;
    crbm_pkg::out_item_t             out_next;

    crbm_pkg::rec_t                  head;
    logic [crbm_pkg::SLOT_N-1:0]     full_mask;
    logic [crbm_pkg::SLOT_N-1:0]     eff_mask;
    logic [crbm_pkg::SLOT_N-1:0]     sel;
    logic [crbm_pkg::SLOT_N-1:0]     remain;
    logic                            load;
    logic                            pop;

    always_comb
    begin
        head = q_mem[head_reg];
        full_mask = '0;
        full_mask[crbm_pkg::SLOT_LABEL] = 1'b1;
        full_mask[crbm_pkg::SLOT_DIAG]  = head.has_diag;
        full_mask[crbm_pkg::SLOT_UP]    = head.has_up;
        full_mask[crbm_pkg::SLOT_LEFT]  = head.has_left;
        full_mask[crbm_pkg::SLOT_SELF]  = head.has_self;
        eff_mask = started_reg ? mask_reg : full_mask;

        sel = '0;
        out_next.report_kind  = crbm_pkg::REPORT_BOUNDARY;
        out_next.pos_x        = head.pos_x;
        out_next.pos_y        = head.pos_y;
        out_next.report_value = '0;
        out_next.region_total = head.total;
        priority if (eff_mask[crbm_pkg::SLOT_LABEL])
        begin
            sel[crbm_pkg::SLOT_LABEL] = 1'b1;
            out_next.report_kind  = crbm_pkg::REPORT_LABEL;
            out_next.report_value = head.label;
        end
        else if (eff_mask[crbm_pkg::SLOT_DIAG])
        begin
            sel[crbm_pkg::SLOT_DIAG] = 1'b1;
            out_next.pos_x        = head.pos_x - crbm_pkg::POS_W'(1);
            out_next.pos_y        = head.pos_y - crbm_pkg::POS_W'(1);
            out_next.report_value = crbm_pkg::LABEL_W'(head.bnd_diag);
        end
        else if (eff_mask[crbm_pkg::SLOT_UP])
        begin
            sel[crbm_pkg::SLOT_UP] = 1'b1;
            out_next.pos_y        = head.pos_y - crbm_pkg::POS_W'(1);
            out_next.report_value = crbm_pkg::LABEL_W'(head.bnd_up);
        end
        else if (eff_mask[crbm_pkg::SLOT_LEFT])
        begin
            sel[crbm_pkg::SLOT_LEFT] = 1'b1;
            out_next.pos_x        = head.pos_x - crbm_pkg::POS_W'(1);
            out_next.report_value = crbm_pkg::LABEL_W'(head.bnd_left);
        end
        else
        begin
            sel[crbm_pkg::SLOT_SELF] = 1'b1;
        end

        remain = eff_mask & ~sel;
        out_next.last = remain == '0;

        load = (count_reg != '0) && (!out_valid_reg || out_ready);
        pop  = load && (remain == '0);

        count_next = count_reg + (rec_valid ? crbm_pkg::QUEUE_CW'(1) : '0)
                     - (pop ? crbm_pkg::QUEUE_CW'(1) : '0);

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end

        out_valid = out_valid_reg;
        out_data  = out_reg;
        q_count   = count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (rec_valid)
            begin
                tail_reg <= tail_reg + crbm_pkg::QUEUE_AW'(1);
            end
            if (pop)
            begin
                head_reg    <= head_reg + crbm_pkg::QUEUE_AW'(1);
                started_reg <= 1'b0;
            end
            else if (load)
            begin
                started_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec_valid)
        begin
            q_mem[tail_reg] <= rec;
        end
        if (load)
        begin
            out_reg  <= out_next;
            mask_reg <= remain;
        end
    end

endmodule

[hdl/component_relabel_boundary_mark_top.sv]
// Top level of the region relabel and boundary mark block with its assertions.
// Path: a label report passes stages p1 and p2, the record queue and the output register.
// Throughput: one report per cycle while out_ready is high; a pixel yields 1 to 5 reports.
// Input intake is one pixel per cycle, limited by a 4-entry credit over pipeline and queue.
// The label tables take one read per port each cycle; forwarding covers in-flight writes.
// Reset: asynchronous, active low; control clears, 640 x 480 geometry, tables are not cleared.
`timescale 1ns / 1ps

module component_relabel_boundary_mark_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [crbm_pkg::CFG_AW-1:0] cfg_addr,
    input  logic [crbm_pkg::CFG_W-1:0]  cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  crbm_pkg::in_item_t          in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output crbm_pkg::out_item_t         out_data
);

    logic                          accept;
    crbm_pkg::pix_t                pix;
    logic                          rec_valid;
    crbm_pkg::rec_t                rec;
    logic [1:0]                    inflight;
    logic [crbm_pkg::QUEUE_CW-1:0] q_count;
    logic [crbm_pkg::QUEUE_CW:0]   occupancy;

    assign occupancy = {1'b0, q_count} + (crbm_pkg::QUEUE_CW + 1)'(inflight);
    assign in_ready  = occupancy < (crbm_pkg::QUEUE_CW + 1)'(crbm_pkg::QUEUE_DEPTH);
    assign accept    = in_valid && in_ready;

    crbm_scan u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .accept   (accept),
        .item     (in_data),
        .pix      (pix)
    );

    crbm_label u_label (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .pix       (pix),
        .rec_valid (rec_valid),
        .rec       (rec),
        .inflight  (inflight)
    );

    crbm_report u_report (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_valid (rec_valid),
        .rec       (rec),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .q_count   (q_count)
    );

    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occupancy <= (crbm_pkg::QUEUE_CW + 1)'(crbm_pkg::QUEUE_DEPTH))
        else $error("Pipeline and queue hold more records than the queue can take.");

    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid |-> q_count < crbm_pkg::QUEUE_CW'(crbm_pkg::QUEUE_DEPTH))
        else $error("A record reached a full queue.");

    a_label_below_total: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.report_kind == crbm_pkg::REPORT_LABEL))
        |-> (crbm_pkg::COUNT_W'(out_data.report_value) < out_data.region_total))
        else $error("A dense label is not below the region total.");

    a_flag_is_bit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.report_kind == crbm_pkg::REPORT_BOUNDARY))
        |-> (out_data.report_value[crbm_pkg::LABEL_W-1:1] == '0))
        else $error("A boundary report carries more than one bit.");

endmodule
